// ===== rtl/core/array_list_insert_delete_sort_macros.svh =====
// ----------------------------------------------------------------------------
// array list assertion macros
// shared concurrent assertion shorthands, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_INSERT_DELETE_SORT_MACROS_SVH
`define ARRAY_LIST_INSERT_DELETE_SORT_MACROS_SVH

// property holds at every edge out of reset
`define ALDS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ALDS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/alds_pkg.sv =====
// ----------------------------------------------------------------------------
// alds_pkg
// field widths, operation and status codes, result word type
// ----------------------------------------------------------------------------
package alds_pkg;

  localparam int unsigned FuncW = 3;
  localparam int unsigned PosW  = 7;
  localparam int unsigned ValW  = 32;
  localparam int unsigned CntW  = 7;
  localparam int unsigned StsW  = 2;

  typedef enum logic [FuncW-1:0] {
    F_APPEND = 3'd0,
    F_INSERT = 3'd1,
    F_DELETE = 3'd2,
    F_SORT   = 3'd3,
    F_READ   = 3'd4,
    F_CLEAR  = 3'd5
  } func_e;

  typedef enum logic [StsW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic signed [ValW-1:0] read_value;
    logic [CntW-1:0]        count;
    status_e                status;
  } res_t;

endpackage

// ===== rtl/core/alds_if.sv =====
// ----------------------------------------------------------------------------
// alds_if
// valid/ready channels for request words and result words
// ----------------------------------------------------------------------------
interface alds_in_if;
  import alds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FuncW-1:0]       func;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink (input valid, input func, input position, input value, output ready);
endinterface

interface alds_out_if;
  import alds_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [ValW-1:0] read_value;
  logic [CntW-1:0]        count;
  logic [StsW-1:0]        status;

  modport source (output valid, output read_value, output count, output status, input ready);
  modport sink (input valid, input read_value, input count, input status, output ready);
endinterface

// ===== rtl/core/array_list_insert_delete_sort.sv =====
// ----------------------------------------------------------------------------
// array_list_insert_delete_sort: bounded signed word list with count
// append, clear, refused or unused ops, insert at count and delete of the last word
//   complete from the idle state; read waits on the registered store read; other inserts
//   and deletes first shift the words behind the position one place, word by word
// sort: up to n - 1 bubble passes, stopping early after a pass with no swap
// one word in flight, next request taken once idle; reset clears count and control
// ----------------------------------------------------------------------------
module array_list_insert_delete_sort #(
  parameter int unsigned DEPTH = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  alds_in_if.sink    in_i,
  alds_out_if.source out_o
);
  import alds_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // sequencer to output register
  logic res_valid;
  logic res_ready;
  res_t res;

  // store ports
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic signed [ValW-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic signed [ValW-1:0] mem_rdata;

  // sequencer: decodes the request word, owns the count, runs the shift
  // and sort loops as read/modify/write sweeps over the store
  alds_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // element store, registered read data
  alds_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output word register, lets the sequencer go idle while a word waits
  alds_oreg u_oreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_o       (out_o)
  );

endmodule

// ===== rtl/core/alds_mem.sv =====
// ----------------------------------------------------------------------------
// alds_mem
// element store, one write and one read port, registered read data
// ----------------------------------------------------------------------------
module alds_mem #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AW-1:0]                 waddr_i,
  input  logic signed [alds_pkg::ValW-1:0] wdata_i,
  input  logic                          re_i,
  input  logic [AW-1:0]                 raddr_i,
  output logic signed [alds_pkg::ValW-1:0] rdata_o
);
  import alds_pkg::*;

  logic signed [ValW-1:0] mem_q [DEPTH];
  logic signed [ValW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/alds_ctrl.sv =====
// ----------------------------------------------------------------------------
// alds_ctrl
// operation sequencer: count register, shifts, bubble sort passes
// ----------------------------------------------------------------------------
`include "array_list_insert_delete_sort_macros.svh"

module alds_ctrl #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  alds_in_if.sink                          in_i,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output alds_pkg::res_t                   res_o,
  output logic                             mem_we_o,
  output logic [AW-1:0]                    mem_waddr_o,
  output logic signed [alds_pkg::ValW-1:0] mem_wdata_o,
  output logic                             mem_re_o,
  output logic [AW-1:0]                    mem_raddr_o,
  input  logic signed [alds_pkg::ValW-1:0] mem_rdata_i
);
  import alds_pkg::*;

  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CW > PosW) ? CW : PosW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_SHUP  = 9'b000000010,
    S_SHDN  = 9'b000000100,
    S_FLUSH = 9'b000001000,
    S_PUT   = 9'b000010000,
    S_SORT  = 9'b000100000,
    S_SWB   = 9'b001000000,
    S_READ  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e                 st_q, st_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   pend_q, pend_d;
  logic                   iss_q, iss_d;
  logic                   up_q, up_d;
  logic                   swp_q, swp_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [AW-1:0]          rd_q, rd_d;
  logic [AW-1:0]          ra_q, ra_d;
  logic [AW-1:0]          lim_q, lim_d;
  logic signed [ValW-1:0] val_q, val_d;
  logic signed [ValW-1:0] cur_q, cur_d;
  logic signed [ValW-1:0] rdv_q, rdv_d;
  status_e                sts_q, sts_d;

  logic [CmpW-1:0] pos_c, cnt_c;
  logic            full;
  logic [AW-1:0]   cnt_a, cnt_m1;

  assign pos_c  = CmpW'(in_i.position);
  assign cnt_c  = CmpW'(cnt_q);
  assign full   = (cnt_q == CW'(DEPTH));
  assign cnt_a  = AW'(cnt_q);
  assign cnt_m1 = AW'(cnt_q - CW'(1));

  assign in_i.ready  = (st_q == S_IDLE);
  assign res_valid_o = (st_q == S_DONE);
  assign res_o       = '{read_value: rdv_q, count: CntW'(cnt_q), status: sts_q};

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    pend_d = pend_q;
    iss_d  = iss_q;
    up_d   = up_q;
    swp_d  = swp_q;
    pos_d  = pos_q;
    rd_d   = rd_q;
    ra_d   = ra_q;
    lim_d  = lim_q;
    val_d  = val_q;
    cur_d  = cur_q;
    rdv_d  = rdv_q;
    sts_d  = sts_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = '0;
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;

    // shift write-back, in the cycle after its read
    if ((st_q == S_SHUP || st_q == S_SHDN || st_q == S_FLUSH) && pend_q) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = up_q ? (ra_q + AW'(1)) : (ra_q - AW'(1));
      mem_wdata_o = mem_rdata_i;
    end

    case (st_q)
      S_IDLE: begin
        if (in_i.valid) begin
          rdv_d = '0;
          sts_d = ST_OK;
          st_d  = S_DONE;
          case (in_i.func)
            F_APPEND: begin
              if (full) begin
                sts_d = ST_FULL;
              end else begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_a;
                mem_wdata_o = in_i.value;
                cnt_d       = cnt_q + CW'(1);
              end
            end
            F_INSERT: begin
              if (full) begin
                sts_d = ST_FULL;
              end else if (pos_c > cnt_c) begin
                sts_d = ST_RANGE;
              end else if (pos_c == cnt_c) begin
                mem_we_o    = 1'b1;
                mem_waddr_o = cnt_a;
                mem_wdata_o = in_i.value;
                cnt_d       = cnt_q + CW'(1);
              end else begin
                pos_d  = AW'(in_i.position);
                val_d  = in_i.value;
                up_d   = 1'b1;
                rd_d   = cnt_m1;
                pend_d = 1'b0;
                st_d   = S_SHUP;
              end
            end
            F_DELETE: begin
              if (pos_c >= cnt_c) begin
                sts_d = ST_RANGE;
              end else if (pos_c + CmpW'(1) == cnt_c) begin
                cnt_d = cnt_q - CW'(1);
              end else begin
                up_d   = 1'b0;
                rd_d   = AW'(in_i.position) + AW'(1);
                pend_d = 1'b0;
                st_d   = S_SHDN;
              end
            end
            F_SORT: begin
              if (cnt_q >= CW'(2)) begin
                lim_d  = cnt_m1;
                rd_d   = '0;
                iss_d  = 1'b1;
                pend_d = 1'b0;
                swp_d  = 1'b0;
                st_d   = S_SORT;
              end
            end
            F_READ: begin
              if (pos_c >= cnt_c) begin
                sts_d = ST_RANGE;
              end else begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(in_i.position);
                st_d        = S_READ;
              end
            end
            F_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
              // unused codes leave everything as it is
            end
          endcase
        end
      end

      S_SHUP: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = rd_q;
        ra_d        = rd_q;
        pend_d      = 1'b1;
        if (rd_q == pos_q) begin
          st_d = S_FLUSH;
        end else begin
          rd_d = rd_q - AW'(1);
        end
      end

      S_SHDN: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = rd_q;
        ra_d        = rd_q;
        pend_d      = 1'b1;
        if (rd_q == cnt_m1) begin
          st_d = S_FLUSH;
        end else begin
          rd_d = rd_q + AW'(1);
        end
      end

      S_FLUSH: begin
        pend_d = 1'b0;
        if (up_q) begin
          st_d = S_PUT;
        end else begin
          cnt_d = cnt_q - CW'(1);
          st_d  = S_DONE;
        end
      end

      S_PUT: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
        mem_wdata_o = val_q;
        cnt_d       = cnt_q + CW'(1);
        st_d        = S_DONE;
      end

      S_SORT: begin
        if (iss_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = rd_q;
          ra_d        = rd_q;
          if (rd_q == lim_q) begin
            iss_d = 1'b0;
          end else begin
            rd_d = rd_q + AW'(1);
          end
        end
        pend_d = iss_q;
        if (pend_q) begin
          if (ra_q == '0) begin
            cur_d = mem_rdata_i;
          end else begin
            // the larger word travels on in cur, the smaller one lands below
            mem_we_o    = 1'b1;
            mem_waddr_o = ra_q - AW'(1);
            if (cur_q > mem_rdata_i) begin
              mem_wdata_o = mem_rdata_i;
              swp_d       = 1'b1;
            end else begin
              mem_wdata_o = cur_q;
              cur_d       = mem_rdata_i;
            end
          end
          if (ra_q == lim_q) begin
            st_d = S_SWB;
          end
        end
      end

      S_SWB: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = lim_q;
        mem_wdata_o = cur_q;
        if (lim_q == AW'(1) || !swp_q) begin
          st_d = S_DONE;
        end else begin
          lim_d  = lim_q - AW'(1);
          rd_d   = '0;
          iss_d  = 1'b1;
          pend_d = 1'b0;
          swp_d  = 1'b0;
          st_d   = S_SORT;
        end
      end

      S_READ: begin
        rdv_d = mem_rdata_i;
        st_d  = S_DONE;
      end

      S_DONE: begin
        if (res_ready_i) begin
          st_d = S_IDLE;
        end
      end

      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      cnt_q  <= '0;
      pend_q <= 1'b0;
      iss_q  <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      iss_q  <= iss_d;
    end
  end

  always_ff @(posedge clk_i) begin
    up_q  <= up_d;
    swp_q <= swp_d;
    pos_q <= pos_d;
    rd_q  <= rd_d;
    ra_q  <= ra_d;
    lim_q <= lim_d;
    val_q <= val_d;
    cur_q <= cur_d;
    rdv_q <= rdv_d;
    sts_q <= sts_d;
  end

  `ALDS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CW'(DEPTH), "count above depth")
  `ALDS_ASSERT(a_port_clash, clk_i, rst_ni, (mem_we_o && mem_re_o) |-> (mem_waddr_o != mem_raddr_o), "read and write hit one entry")
  `ALDS_ASSERT(a_full_sts, clk_i, rst_ni, (st_q == S_DONE && sts_q == ST_FULL) |-> full, "full status while not full")
  `ALDS_ASSERT_NEXT(a_sort_cnt, clk_i, rst_ni, st_q == S_SORT || st_q == S_SWB, $stable(cnt_q), "sort changed count")
  `ALDS_ASSERT_NEXT(a_clear, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.func == F_CLEAR, cnt_q == '0, "clear left count")

endmodule

// ===== rtl/core/alds_oreg.sv =====
// ----------------------------------------------------------------------------
// alds_oreg
// one-word output register between sequencer and result channel
// ----------------------------------------------------------------------------
module alds_oreg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           res_valid_i,
  output logic           res_ready_o,
  input  alds_pkg::res_t res_i,
  alds_out_if.source     out_o
);
  import alds_pkg::*;

  logic vld_q, vld_d;
  res_t dat_q;
  logic load;

  assign res_ready_o = !vld_q || out_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dat_q <= res_i;
    end
  end

  assign out_o.valid      = vld_q;
  assign out_o.read_value = dat_q.read_value;
  assign out_o.count      = dat_q.count;
  assign out_o.status     = dat_q.status;

endmodule
